### hdl/tebt_pkg.sv
// Shared types, widths and constants for the triangle edge/barycentric test.
// No dependencies; every other file imports this package.
package tebt_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = MAG_W + FRAC_W + 2;
  localparam int DEN_W      = MAG_W + 1;
  localparam int Q_W        = FRAC_W + 2;
  localparam int CMP_W      = DEN_W + Q_W + 1;
  localparam int W_W        = 18;
  localparam int W_ONE      = 65536;
  localparam int W_MAX      = 131071;
  localparam int W_NEG_LIM  = 131072;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_V0X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V0Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V1X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V1Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V2X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V2Y = 3'd5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_val_t;
  typedef logic signed [W_W-1:0]        weight_t;

  typedef struct packed {
    coord_t v0x, v0y, v1x, v1y, v2x, v2y;
  } tri_t;

  typedef struct packed {
    cross_val_t c0, c1, d;
    logic       in_box;
  } cross_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
    logic             ovf;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic in_box;
    logic degen;
    logic ccw;
  } side_t;

  typedef struct packed {
    lane_t l0, l1;
    side_t side;
  } quot_t;

  function automatic diff_t diff(coord_t a, coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

endpackage

### hdl/tebt_if.sv
// Valid/ready channel interfaces for sample points and coverage results.
// Depends on tebt_pkg.
interface point_if import tebt_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface result_if import tebt_pkg::*;;
  logic    valid;
  logic    ready;
  logic    inside_res;
  weight_t weight0;
  weight_t weight1;
  weight_t weight2;
  logic    counter_clockwise;
  logic    degenerate;
  modport source (output valid, inside_res, weight0, weight1, weight2,
                  counter_clockwise, degenerate, input ready);
  modport sink   (input valid, inside_res, weight0, weight1, weight2,
                  counter_clockwise, degenerate, output ready);
endinterface

### hdl/tebt_front.sv
// Front stages: edge differences and box test, products, cross sums.
// Depends on tebt_pkg and point_if.
module tebt_front import tebt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  tri_t   tri_cfg,
  point_if.sink  pt,
  output logic   out_valid,
  input  logic   out_ready,
  output cross_t out_data
);

  logic  va, vb, vc;
  logic  rdy_a, rdy_b, rdy_c;
  diff_t a0x, a0y, b0x, b0y, a1x, a1y, b1x, b1y, dx, dy;
  logic  box_a, box_b;
  prod_t pa, pb, pc, pd, pe, pf;
  coord_t min_x, max_x, min_y, max_y;
  logic  in_box;

  // each stage moves when empty or when the next one moves
  assign rdy_c    = !vc || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign pt.ready = rdy_a;

  // bounding box of the three vertices
  always_comb begin
    min_x = tri_cfg.v0x;
    max_x = tri_cfg.v0x;
    min_y = tri_cfg.v0y;
    max_y = tri_cfg.v0y;
    if (tri_cfg.v1x < min_x) min_x = tri_cfg.v1x;
    if (tri_cfg.v2x < min_x) min_x = tri_cfg.v2x;
    if (tri_cfg.v1x > max_x) max_x = tri_cfg.v1x;
    if (tri_cfg.v2x > max_x) max_x = tri_cfg.v2x;
    if (tri_cfg.v1y < min_y) min_y = tri_cfg.v1y;
    if (tri_cfg.v2y < min_y) min_y = tri_cfg.v2y;
    if (tri_cfg.v1y > max_y) max_y = tri_cfg.v1y;
    if (tri_cfg.v2y > max_y) max_y = tri_cfg.v2y;
    in_box = (pt.point_x >= min_x) && (pt.point_x <= max_x) &&
             (pt.point_y >= min_y) && (pt.point_y <= max_y);
  end

  // stage A: edge vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= pt.valid;
    end
    if (rdy_a) begin
      a0x   <= diff(tri_cfg.v1x, pt.point_x);
      a0y   <= diff(tri_cfg.v1y, pt.point_y);
      b0x   <= diff(tri_cfg.v2x, tri_cfg.v1x);
      b0y   <= diff(tri_cfg.v2y, tri_cfg.v1y);
      a1x   <= diff(tri_cfg.v2x, pt.point_x);
      a1y   <= diff(tri_cfg.v2y, pt.point_y);
      b1x   <= diff(tri_cfg.v0x, tri_cfg.v2x);
      b1y   <= diff(tri_cfg.v0y, tri_cfg.v2y);
      dx    <= diff(tri_cfg.v1x, tri_cfg.v0x);
      dy    <= diff(tri_cfg.v1y, tri_cfg.v0y);
      box_a <= in_box;
    end
  end

  // stage B: six products
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
    if (rdy_b) begin
      pa    <= PROD_W'(a0x) * PROD_W'(b0y);
      pb    <= PROD_W'(a0y) * PROD_W'(b0x);
      pc    <= PROD_W'(a1x) * PROD_W'(b1y);
      pd    <= PROD_W'(a1y) * PROD_W'(b1x);
      pe    <= PROD_W'(dx) * PROD_W'(b0y);
      pf    <= PROD_W'(dy) * PROD_W'(b0x);
      box_b <= box_a;
    end
  end

  // stage C: cross products and doubled area
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdy_c) begin
      vc <= vb;
    end
    if (rdy_c) begin
      out_data.c0     <= CROSS_W'(pa) - CROSS_W'(pb);
      out_data.c1     <= CROSS_W'(pc) - CROSS_W'(pd);
      out_data.d      <= CROSS_W'(pe) - CROSS_W'(pf);
      out_data.in_box <= box_b;
    end
  end

  assign out_valid = vc;

endmodule

### hdl/tebt_div.sv
// Restoring divider pipeline, one quotient bit per stage, two lanes.
// Depends on tebt_pkg.
module tebt_div import tebt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  cross_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output quot_t  out_data
);

  logic  v   [0:Q_W];
  logic  rdy [0:Q_W+1];
  quot_t st  [0:Q_W];
  quot_t prep;

  function automatic lane_t setup(cross_val_t c, cross_val_t d);
    logic [MAG_W-1:0] mc, md;
    lane_t            r;
    mc    = c[CROSS_W-1] ? MAG_W'(-c) : MAG_W'(c);
    md    = d[CROSS_W-1] ? MAG_W'(-d) : MAG_W'(d);
    r.rem = NUM_W'({mc, {(FRAC_W + 1){1'b0}}}) + NUM_W'(md);
    r.den = {md, 1'b0};
    r.q   = '0;
    r.ovf = CMP_W'(r.rem) >= (CMP_W'(r.den) << Q_W);
    r.neg = c[CROSS_W-1] ^ d[CROSS_W-1];
    return r;
  endfunction

  function automatic lane_t step(lane_t l, int b);
    logic [CMP_W-1:0] sd;
    lane_t            r;
    sd = CMP_W'(l.den) << b;
    r  = l;
    if (CMP_W'(l.rem) >= sd) begin
      r.rem  = l.rem - NUM_W'(sd);
      r.q[b] = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    prep.l0          = setup(in_data.c0, in_data.d);
    prep.l1          = setup(in_data.c1, in_data.d);
    prep.side.in_box = in_data.in_box;
    prep.side.degen  = (in_data.d == '0);
    prep.side.ccw    = !in_data.d[CROSS_W-1];
  end

  assign rdy[Q_W+1] = out_ready;
  assign in_ready   = rdy[0];

  // magnitudes, scaled numerator and overflow check
  assign rdy[0] = !v[0] || rdy[1];
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
    if (rdy[0]) begin
      st[0] <= prep;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    assign rdy[k+1] = !v[k+1] || rdy[k+2];
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (rdy[k+1]) begin
        v[k+1] <= v[k];
      end
      if (rdy[k+1]) begin
        st[k+1].l0   <= step(st[k].l0, Q_W - 1 - k);
        st[k+1].l1   <= step(st[k].l1, Q_W - 1 - k);
        st[k+1].side <= st[k].side;
      end
    end
  end

  assign out_valid = v[Q_W];
  assign out_data  = st[Q_W];

endmodule

### hdl/tebt_out.sv
// Output stage: signs, saturation, third weight and coverage decision.
// Depends on tebt_pkg and result_if.
module tebt_out import tebt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  quot_t    in_data,
  result_if.source res
);

  logic                 vo;
  weight_t              w0, w1, w2;
  logic signed [W_W+1:0] s2;

  function automatic weight_t finish(lane_t l);
    if (!l.neg) begin
      return (l.ovf || l.q > Q_W'(W_MAX)) ? weight_t'(W_MAX) : weight_t'(l.q);
    end
    return (l.ovf || l.q > Q_W'(W_NEG_LIM)) ? weight_t'(-W_NEG_LIM) : -weight_t'(l.q);
  endfunction

  always_comb begin
    w0 = finish(in_data.l0);
    w1 = finish(in_data.l1);
    s2 = (W_W + 2)'(W_ONE) - (W_W + 2)'(w0) - (W_W + 2)'(w1);
    if (s2 > (W_W + 2)'(W_MAX)) w2 = weight_t'(W_MAX);
    else if (s2 < -(W_W + 2)'(W_NEG_LIM)) w2 = weight_t'(-W_NEG_LIM);
    else w2 = weight_t'(s2);
  end

  assign in_ready = !vo || res.ready;

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (in_ready) begin
      vo <= in_valid;
    end
    if (in_ready) begin
      if (in_data.side.degen) begin
        res.weight0           <= '0;
        res.weight1           <= '0;
        res.weight2           <= '0;
        res.inside_res        <= 1'b0;
        res.counter_clockwise <= 1'b0;
        res.degenerate        <= 1'b1;
      end else begin
        res.weight0           <= w0;
        res.weight1           <= w1;
        res.weight2           <= w2;
        res.inside_res        <= in_data.side.in_box && !w0[W_W-1] && !w1[W_W-1] &&
                                 !w2[W_W-1];
        res.counter_clockwise <= in_data.side.ccw;
        res.degenerate        <= 1'b0;
      end
    end
  end

  assign res.valid = vo;

endmodule

### hdl/triangle_edge_barycentric_test_core.sv
// Top level of the triangle coverage test: vertex registers and pipeline.
// Depends on tebt_pkg, the channel interfaces, tebt_front, tebt_div, tebt_out.
//
// Usage: write the six vertex coordinates (signed Q12.4) through cfg_we,
// cfg_index and cfg_data while no point is in flight; indexes past the
// vertex list are ignored. Send sample points on pt; each point yields one
// result on res: inside flag, three Q2.16 barycentric weights, winding and
// zero-area flags.
// From a point transfer to its result there are three stages of edge
// arithmetic, one setup stage, eighteen divider stages (one quotient bit
// each) and the output register. Throughput is one point per cycle
// while res.ready is high; the divider pipeline sets the depth.
// Every stage moves when it is empty or its successor moves, so points keep
// flowing into empty slots while a result waits at the output; once all
// slots are full, pt.ready drops and nothing is lost or repeated.
// Reset (synchronous, active high) clears the vertices to zero and empties
// the pipeline.
module triangle_edge_barycentric_test_core import tebt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  point_if.sink                 pt,
  result_if.source              res
);

  tri_t   tri_cfg;
  logic   fr_valid, fr_ready, dv_valid, dv_ready;
  cross_t fr_data;
  quot_t  dv_data;

  // vertex registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tri_cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_V0X: tri_cfg.v0x <= coord_t'(cfg_data);
        REG_V0Y: tri_cfg.v0y <= coord_t'(cfg_data);
        REG_V1X: tri_cfg.v1x <= coord_t'(cfg_data);
        REG_V1Y: tri_cfg.v1y <= coord_t'(cfg_data);
        REG_V2X: tri_cfg.v2x <= coord_t'(cfg_data);
        REG_V2Y: tri_cfg.v2y <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  tebt_front u_front (
    .clk(clk), .rst(rst), .tri_cfg(tri_cfg), .pt(pt),
    .out_valid(fr_valid), .out_ready(fr_ready), .out_data(fr_data)
  );

  tebt_div u_div (
    .clk(clk), .rst(rst),
    .in_valid(fr_valid), .in_ready(fr_ready), .in_data(fr_data),
    .out_valid(dv_valid), .out_ready(dv_ready), .out_data(dv_data)
  );

  tebt_out u_out (
    .clk(clk), .rst(rst),
    .in_valid(dv_valid), .in_ready(dv_ready), .in_data(dv_data), .res(res)
  );

endmodule

### hdl/tebt_checker.sv
// Port-level assertions for the triangle coverage test, bound to the top.
// Depends on tebt_pkg and triangle_edge_barycentric_test_core.
module tebt_checker import tebt_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input logic    inside_res,
  input weight_t weight0,
  input weight_t weight1,
  input weight_t weight2,
  input logic    counter_clockwise,
  input logic    degenerate
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // zero area forces zero weights and no coverage
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> weight0 == '0 && weight1 == '0 && weight2 == '0 &&
                                !inside_res && !counter_clockwise)
    else $error("zero-area result not cleared");

  // coverage implies all weights non-negative
  a_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_res |-> !weight0[W_W-1] && !weight1[W_W-1] && !weight2[W_W-1])
    else $error("inside with a negative weight");

endmodule

bind triangle_edge_barycentric_test_core tebt_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(res.valid), .out_ready(res.ready),
  .inside_res(res.inside_res), .weight0(res.weight0), .weight1(res.weight1),
  .weight2(res.weight2), .counter_clockwise(res.counter_clockwise),
  .degenerate(res.degenerate)
);
